// ===== hdl/afl_pkg.sv =====
package afl_pkg;

   localparam int CODE_W  = 8;
   localparam int MAG_W   = 15;
   localparam int LEVEL_W = 7;
   localparam int PROD_W  = 22;

   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [MAG_W-1:0]   mag_type;
   typedef logic [LEVEL_W-1:0] level_type;

   localparam code_type     ALAW_TOGGLE   = 8'h55;
   localparam logic [2:0]   ALAW_SEG_MASK = 3'h7;
   localparam logic [3:0]   ALAW_MAN_MASK = 4'hF;
   localparam mag_type      ALAW_HALF     = 15'h008;
   localparam mag_type      ALAW_SEG_BIAS = 15'h108;
   localparam logic [15:0]  FULL_SCALE    = 16'd32767;
   localparam logic [6:0]   PCT_SCALE     = 7'd100;
   localparam level_type    LEVEL_MAX     = 7'd100;
   localparam mag_type      MAG_MAX       = 15'd32256;

   // multiply-shift reciprocal of 10, exact for inputs below 1029
   localparam logic [7:0]   RECIP_TEN     = 8'd205;
   localparam int           RECIP_SHIFT   = 11;

   typedef struct packed {
      logic    go;
      logic    last;
      mag_type mag;
   } step_type;

   function automatic level_type div10(input logic [9:0] value);
      logic [17:0] prod;
      logic [17:0] shifted;
      prod    = 18'(value) * 18'(RECIP_TEN);
      shifted = prod >> RECIP_SHIFT;
      return shifted[LEVEL_W-1:0];
   endfunction

endpackage

// ===== hdl/afl_if.sv =====
interface afl_req_if;
   logic               valid;
   logic               ready;
   afl_pkg::code_type  alaw_code;
   logic               frame_end;

   modport source (output valid, output alaw_code, output frame_end, input ready);
   modport sink   (input valid, input alaw_code, input frame_end, output ready);
endinterface

interface afl_rsp_if;
   logic               valid;
   logic               ready;
   afl_pkg::level_type level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

// ===== hdl/alaw_frame_level_meter_top.sv =====
// channel   dir  signals                              transfer when
// req_ch    in   valid ready alaw_code frame_end      valid && ready
// rsp_ch    out  valid ready level                    valid && ready
//
// One byte per cycle sustained unless a frame-end byte waits on a stalled result;
// a new byte can enter the input register as the one before it leaves.
// A frame-end byte loads its level at the edge it leaves the input register.
// Reset is synchronous and clears the peak, the smoothed level and both valids.
// A stalled result holds only frame-end bytes; the bytes behind one wait with it.
module alaw_frame_level_meter_top (
   input  logic      clock,
   input  logic      reset,
   afl_req_if.sink   req_ch,
   afl_rsp_if.source rsp_ch
);
   import afl_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   code_type s1_code_ff;
   logic     s1_last_ff;
   logic     out_free;
   logic     s1_go;
   logic     req_take;
   mag_type  mag;
   step_type step;

   assign s1_go        = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_code_ff <= req_ch.alaw_code;
         s1_last_ff <= req_ch.frame_end;
      end
   end

   afl_expand u_expand (
      .alaw_code (s1_code_ff),
      .mag       (mag)
   );

   assign step = '{go: s1_go, last: s1_last_ff, mag: mag};

   afl_meter u_meter (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== hdl/afl_expand.sv =====
module afl_expand (
   input  afl_pkg::code_type alaw_code,
   output afl_pkg::mag_type  mag
);
   import afl_pkg::*;

   code_type   toggled;
   logic [2:0] seg;
   logic [3:0] man;
   mag_type    base;
   logic [2:0] shift;

   always_comb begin
      toggled = alaw_code ^ ALAW_TOGGLE;
      seg     = toggled[6:4] & ALAW_SEG_MASK;
      man     = toggled[3:0] & ALAW_MAN_MASK;
      shift   = seg - 3'd1;
      base    = {7'd0, man, 4'd0} + ALAW_SEG_BIAS;
      if (seg == 3'd0) begin
         mag = {7'd0, man, 4'd0} + ALAW_HALF;
      end else begin
         mag = base << shift;
      end
   end

endmodule

// ===== hdl/afl_meter.sv =====
module afl_meter (
   input  logic              clock,
   input  logic              reset,
   input  afl_pkg::step_type step,
   output logic              out_free,
   afl_rsp_if.source         rsp_ch
);
   import afl_pkg::*;

   mag_type             peak_ff, peak_in;
   level_type           level_ff, level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   level_type           rsp_level_ff;

   mag_type             peak_next;
   logic [PROD_W-1:0]   scaled;
   logic [6:0]          quot0;
   logic [15:0]         remain;
   level_type           pct;
   logic [9:0]          old_term;
   logic [9:0]          new_term;
   logic                emit;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign emit          = step.go && step.last;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.level  = rsp_level_ff;

   always_comb begin
      peak_next = (step.mag > peak_ff) ? step.mag : peak_ff;
      // peak*100/32767: divide by 32768, then one correction step
      scaled    = PROD_W'(peak_next) * PROD_W'(PCT_SCALE);
      quot0     = scaled[PROD_W-1:MAG_W];
      remain    = {1'b0, scaled[MAG_W-1:0]} + 16'(quot0);
      pct       = (remain >= FULL_SCALE) ? quot0 + 7'd1 : quot0;
      old_term  = 10'(level_ff) * 10'd6;
      new_term  = 10'(pct) * 10'd4;

      peak_in      = peak_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (step.go) begin
         peak_in = step.last ? '0 : peak_next;
      end
      if (emit) begin
         level_in     = div10(old_term) + div10(new_term);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         peak_ff      <= peak_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_level_ff <= level_in;
      end
   end

   a_peak_clear: assert property (@(posedge clock) disable iff (reset)
      emit |=> peak_ff == '0)
      else $error("peak not cleared after frame end");

   a_peak_grows: assert property (@(posedge clock) disable iff (reset)
      step.go && !step.last |=> peak_ff >= $past(peak_ff) && peak_ff <= MAG_MAX)
      else $error("peak update out of order");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_MAX)
      else $error("smoothed level out of range");

   a_rsp_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff == level_ff)
      else $error("pending result differs from smoothed level");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result register overwritten");

endmodule
